// ===== hdl/qpt_pkg.sv =====
// Shared types and constants of the quadrature position tracker.
// Holds the beat structs, command and register codes, and the transition table.
// No dependencies.
package qpt_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivCntW = 3;

  localparam logic [CmdW-1:0] CMD_SAMPLE = 3'd0;
  localparam logic [CmdW-1:0] CMD_SET    = 3'd1;
  localparam logic [CmdW-1:0] CMD_SAVE   = 3'd2;
  localparam logic [CmdW-1:0] CMD_RESTORE = 3'd3;
  localparam logic [CmdW-1:0] CMD_SYNC   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_FROM     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RANGE_TO       = 2'd2;

  localparam logic [CountW-1:0] WrapMark        = 8'hFF;
  localparam logic [CountW-1:0] TicksReset      = 8'd4;
  localparam logic [CountW-1:0] RangeFromReset  = 8'd0;
  localparam logic [CountW-1:0] RangeToReset    = 8'd63;
  localparam logic [CountW-1:0] LowerReset      = 8'd0;
  localparam logic [CountW-1:0] UpperReset      = 8'd255;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic              phase_a;
    logic              phase_b;
    logic [CountW-1:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] position;
    logic [CountW-1:0] raw_count;
    logic              moved;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // apply the accepted beat and seed the divider
    logic div_step;  // one restoring division step
    logic out_load;  // capture the result into the output register
  } dp_cmd_t;

  // Count increment per transition index {new B, new A, old B, old A}, mod 256
  function automatic logic [CountW-1:0] step_inc(input logic [3:0] idx);
    logic [CountW-1:0] inc;
    case (idx)
      4'd0:  inc = 8'd0;
      4'd1:  inc = 8'd1;
      4'd2:  inc = 8'd255;
      4'd3:  inc = 8'd2;
      4'd4:  inc = 8'd255;
      4'd5:  inc = 8'd0;
      4'd6:  inc = 8'd254;
      4'd7:  inc = 8'd1;
      4'd8:  inc = 8'd1;
      4'd9:  inc = 8'd254;
      4'd10: inc = 8'd0;
      4'd11: inc = 8'd255;
      4'd12: inc = 8'd2;
      4'd13: inc = 8'd255;
      4'd14: inc = 8'd1;
      4'd15: inc = 8'd0;
      default: inc = 8'd0;
    endcase
    return inc;
  endfunction

endpackage

// ===== hdl/quadrature_position_tracker.sv =====
// Quadrature position tracker top level: controller and datapath.
// Uses qpt_pkg, qpt_ctrl and qpt_dp.
//
// Each input beat is taken, which updates the raw count, then passes eight
// steps of the bit-serial divider that forms the reported position, and is
// loaded into the output register once that register is free or being
// drained. A finished result waits in the output register while the next
// beat is taken. Configuration writes are taken every cycle and recompute
// the window bounds at once; write them only while no beat is in flight.
module quadrature_position_tracker
  import qpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  dp_cmd_t dp_cmd;

  assign cfg_ready_o = 1'b1;

  qpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  qpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

  // a taken beat blocks the input until its result is loaded
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while a beat is in flight");

  // the result is loaded on the same edge that frees the input
  a_load_frees_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded without returning to idle");

  // no command strobes overlap
  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({dp_cmd.take, dp_cmd.div_step, dp_cmd.out_load}) <= 1)
    else $error("overlapping datapath commands");

endmodule

// ===== hdl/qpt_ctrl.sv =====
// Controller of the quadrature position tracker: sequences take, divide and
// output load, and owns the input ready and output valid. Uses qpt_pkg.
module qpt_ctrl
  import qpt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               take, load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign take = in_valid_i && in_ready_o;
  // load once the output register is free or being drained this cycle
  assign load = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  assign cmd_o.take     = take;
  assign cmd_o.div_step = (state_q == S_DIV);
  assign cmd_o.out_load = load;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == {DivCntW{1'b1}}) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/qpt_dp.sv =====
// Datapath of the quadrature position tracker: configuration and bounds,
// count update, save/restore, bit-serial divider and output register.
// Uses qpt_pkg.
module qpt_dp
  import qpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  in_item_t           in_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output out_item_t          out_data_o
);

  logic [CountW-1:0] ticks_q, from_q, to_q;
  logic [CountW-1:0] lower_q, upper_q, count_q, count_d;
  logic [CountW-1:0] saved_count_q, saved_lower_q, saved_upper_q;
  logic [1:0]        last_q;
  logic [CountW-1:0] rem_q, quo_q;
  logic              moved_q;
  out_item_t         out_q;

  // Bounds from the registers as they stand after this write
  logic [CountW-1:0]   ticks_n, from_n, to_n;
  logic [2*CountW-1:0] lower_prod, upper_prod;
  logic [CountW-1:0]   lower_n, upper_n;

  always_comb begin
    ticks_n = (cfg_index_i == REG_TICKS_PER_STEP) ? cfg_data_i : ticks_q;
    from_n  = (cfg_index_i == REG_RANGE_FROM)     ? cfg_data_i : from_q;
    to_n    = (cfg_index_i == REG_RANGE_TO)       ? cfg_data_i : to_q;
    lower_prod = (2*CountW)'(from_n) * (2*CountW)'(ticks_n);
    upper_prod = (2*CountW)'(to_n) * (2*CountW)'(ticks_n);
    lower_n = lower_prod[CountW-1:0];
    upper_n = upper_prod[CountW-1:0] + ticks_n - CountW'(1);
  end

  // Sample step: table increment, then window wrap
  logic [3:0]          trans_idx;
  logic [CountW-1:0]   stepped, wrapped;
  logic [2*CountW-1:0] set_prod;

  always_comb begin
    trans_idx = {in_data_i.phase_b, in_data_i.phase_a, last_q};
    stepped   = count_q + step_inc(trans_idx);
    if (stepped == WrapMark) begin
      wrapped = upper_q;
    end else if (stepped > upper_q) begin
      wrapped = lower_q;
    end else begin
      wrapped = stepped;
    end
    set_prod = (2*CountW)'(in_data_i.new_position) * (2*CountW)'(ticks_q);
  end

  always_comb begin
    count_d = count_q;
    case (in_data_i.command)
      CMD_SAMPLE:  count_d = wrapped;
      CMD_SET:     count_d = set_prod[CountW-1:0];
      CMD_RESTORE: count_d = saved_count_q;
      default:     count_d = count_q;
    endcase
  end

  // Restoring divide step; a zero divisor yields all ones
  logic [CountW:0]   shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[CountW-1]};
    fits    = (shifted >= {1'b0, ticks_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q       <= TicksReset;
      from_q        <= RangeFromReset;
      to_q          <= RangeToReset;
      lower_q       <= LowerReset;
      upper_q       <= UpperReset;
      count_q       <= '0;
      last_q        <= '0;
      saved_count_q <= '0;
      saved_lower_q <= '0;
      saved_upper_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TICKS_PER_STEP, REG_RANGE_FROM, REG_RANGE_TO: begin
            ticks_q <= ticks_n;
            from_q  <= from_n;
            to_q    <= to_n;
            lower_q <= lower_n;
            upper_q <= upper_n;
          end
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        count_q <= count_d;
        case (in_data_i.command)
          CMD_SAMPLE, CMD_SYNC: last_q <= {in_data_i.phase_b, in_data_i.phase_a};
          CMD_SAVE: begin
            saved_count_q <= count_q;
            saved_lower_q <= lower_q;
            saved_upper_q <= upper_q;
          end
          CMD_RESTORE: begin
            lower_q <= saved_lower_q;
            upper_q <= saved_upper_q;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      quo_q   <= count_d;
      rem_q   <= '0;
      moved_q <= (in_data_i.command == CMD_SAMPLE);
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[CountW-2:0], fits};
      rem_q <= fits ? CountW'(shifted - {1'b0, ticks_q}) : shifted[CountW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.position  <= quo_q;
      out_q.raw_count <= count_q;
      out_q.moved     <= moved_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== tb/sv/quadrature_position_tracker_tb.sv =====
// Self-checking bench for the quadrature position tracker: random encoder walks and commands.
// The bench tracks count, window and saved state on its own and checks every result beat.
// Depends on qpt_pkg and quadrature_position_tracker.
module quadrature_position_tracker_tb;
  import qpt_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 24;
  localparam logic [CmdW-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CmdW-1:0] CMD_LAST_UNUSED  = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_SPARE     = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CountW-1:0]  cfg_data  = '0;

  quadrature_position_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Tracker state as the bench sees it
  logic [1:0]        enc_last   = 2'b00;  // {B, A}
  logic [CountW-1:0] enc_count  = '0;
  logic [CountW-1:0] win_lower  = LowerReset;
  logic [CountW-1:0] win_upper  = UpperReset;
  logic [CountW-1:0] kept_count = '0;
  logic [CountW-1:0] kept_lower = '0;
  logic [CountW-1:0] kept_upper = '0;
  logic [CountW-1:0] div_reg    = TicksReset;
  logic [CountW-1:0] from_reg   = RangeFromReset;
  logic [CountW-1:0] to_reg     = RangeToReset;

  in_item_t  encoder_beats_q[$];
  out_item_t position_reports_q[$];

  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Stimulus walker: position on the Gray cycle 00 -> B -> AB -> A
  logic [1:0] walk_g = 2'd0;
  bit         walk_up = 1'b1;

  function automatic logic [1:0] gray_of(input logic a, input logic b);
    case ({b, a})
      2'b00:   return 2'd0;
      2'b10:   return 2'd1;
      2'b11:   return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] phases_of(input logic [1:0] g);
    case (g)
      2'd0:    return 2'b00;
      2'd1:    return 2'b10;
      2'd2:    return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic void refresh_window();
    logic [15:0] lo;
    logic [15:0] hi;
    lo = from_reg * div_reg;
    hi = to_reg * div_reg + div_reg - 16'd1;
    win_lower = lo[CountW-1:0];
    win_upper = hi[CountW-1:0];
  endfunction

  function automatic out_item_t advance_tracker(input in_item_t beat);
    out_item_t   rep;
    logic [1:0]  diff;
    logic [CountW-1:0] delta;
    logic [15:0] prod;
    rep = '0;
    case (beat.command)
      CMD_SAMPLE: begin
        diff = gray_of(beat.phase_a, beat.phase_b) - gray_of(enc_last[0], enc_last[1]);
        case (diff)
          2'd1:    delta = 8'd1;
          2'd3:    delta = 8'hFF;
          // a skipped state: direction follows the starting pair
          2'd2:    delta = (enc_last[0] == enc_last[1]) ? 8'd2 : 8'hFE;
          default: delta = 8'd0;
        endcase
        enc_count = enc_count + delta;
        enc_last  = {beat.phase_b, beat.phase_a};
        if (enc_count == WrapMark)
          enc_count = win_upper;
        else if (enc_count > win_upper)
          enc_count = win_lower;
        rep.moved = 1'b1;
      end
      CMD_SET: begin
        prod = beat.new_position * div_reg;
        enc_count = prod[CountW-1:0];
      end
      CMD_SAVE: begin
        kept_count = enc_count;
        kept_lower = win_lower;
        kept_upper = win_upper;
      end
      CMD_RESTORE: begin
        enc_count = kept_count;
        win_lower = kept_lower;
        win_upper = kept_upper;
      end
      CMD_SYNC: enc_last = {beat.phase_b, beat.phase_a};
      default: ;
    endcase
    rep.position  = (div_reg != '0) ? enc_count / div_reg : 8'hFF;
    rep.raw_count = enc_count;
    return rep;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready)
        position_reports_q.push_back(advance_tracker(in_data));
      if ($urandom_range(0, 59) == 0)
        in_calm <= !in_calm;
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (encoder_beats_q.size() != 0) begin
          in_data  <= encoder_beats_q.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output back-pressure
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (position_reports_q.size() == 0) begin
          $error("result beat with nothing expected: position %0d raw_count %0d moved %0d",
                 out_data.position, out_data.raw_count, out_data.moved);
          mismatch_cnt++;
        end else begin
          want = position_reports_q.pop_front();
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            mismatch_cnt++;
          end
          if (out_data.raw_count !== want.raw_count) begin
            $error("raw_count: expected %0d, got %0d", want.raw_count, out_data.raw_count);
            mismatch_cnt++;
          end
          if (out_data.moved !== want.moved) begin
            $error("moved: expected %0d, got %0d", want.moved, out_data.moved);
            mismatch_cnt++;
          end
        end
      end
      if ($urandom_range(0, 59) == 0)
        out_calm <= !out_calm;
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap(out_calm);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TICKS_PER_STEP: div_reg  = val;
      REG_RANGE_FROM:     from_reg = val;
      REG_RANGE_TO:       to_reg   = val;
      default: ;
    endcase
    if (idx != REG_SPARE)
      refresh_window();
  endtask

  task automatic push_beat(input logic [CmdW-1:0] cmd, input logic a, input logic b,
                           input logic [CountW-1:0] np);
    in_item_t beat;
    beat.command      = cmd;
    beat.phase_a      = a;
    beat.phase_b      = b;
    beat.new_position = np;
    encoder_beats_q.push_back(beat);
  endtask

  task automatic push_random_beats(input int unsigned n);
    int unsigned r;
    int unsigned s;
    logic [1:0]  ph;
    logic [CountW-1:0] np;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      np = $urandom_range(0, 255);
      if (r < 75) begin
        // mostly legal single steps in runs, so the count sweeps across the window
        if ($urandom_range(0, 19) == 0)
          walk_up = !walk_up;
        s = $urandom_range(0, 99);
        if (s < 70)
          walk_g = walk_g + (walk_up ? 2'd1 : 2'd3);
        else if (s < 90 && s >= 82)
          walk_g = walk_g + 2'd2;
        else if (s >= 90)
          walk_g = $urandom_range(0, 3);
        ph = phases_of(walk_g);
        push_beat(CMD_SAMPLE, ph[0], ph[1], np);
      end else if (r < 81) begin
        push_beat(CMD_SET, $urandom_range(0, 1), $urandom_range(0, 1), np);
      end else if (r < 85) begin
        push_beat(CMD_SAVE, $urandom_range(0, 1), $urandom_range(0, 1), np);
      end else if (r < 89) begin
        push_beat(CMD_RESTORE, $urandom_range(0, 1), $urandom_range(0, 1), np);
      end else if (r < 95) begin
        walk_g = $urandom_range(0, 3);
        ph = phases_of(walk_g);
        push_beat(CMD_SYNC, ph[0], ph[1], np);
      end else begin
        push_beat($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED),
                  $urandom_range(0, 1), $urandom_range(0, 1), np);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (encoder_beats_q.size() != 0 || in_valid || position_reports_q.size() != 0);
  endtask

  task automatic run_phase(input logic [CountW-1:0] div, input logic [CountW-1:0] lo,
                           input logic [CountW-1:0] hi, input int unsigned n);
    write_reg(REG_TICKS_PER_STEP, div);
    write_reg(REG_RANGE_FROM, lo);
    write_reg(REG_RANGE_TO, hi);
    push_random_beats(n);
    wait_drained();
  endtask

  initial begin
    logic [CountW-1:0] div;
    logic [CountW-1:0] lo;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every transition kind, set/save/restore, sync, unused codes
    push_beat(CMD_SET,     1'b0, 1'b0, 8'd0);
    push_beat(CMD_SAMPLE,  1'b0, 1'b0, 8'd255);
    push_beat(CMD_SAMPLE,  1'b1, 1'b0, 8'd0);    // below zero: wrap mark goes to the top
    push_beat(CMD_SAMPLE,  1'b1, 1'b1, 8'd0);
    push_beat(CMD_SAMPLE,  1'b0, 1'b1, 8'd0);
    push_beat(CMD_SAMPLE,  1'b0, 1'b0, 8'd0);
    push_beat(CMD_SAMPLE,  1'b0, 1'b1, 8'd0);
    push_beat(CMD_SAMPLE,  1'b1, 1'b0, 8'd0);    // skipped states on the A-B diagonal; the 00-11 one follows the sync
    push_beat(CMD_SAMPLE,  1'b0, 1'b1, 8'd0);
    push_beat(CMD_SYNC,    1'b0, 1'b0, 8'd0);
    push_beat(CMD_SAMPLE,  1'b1, 1'b1, 8'd0);
    push_beat(CMD_SAMPLE,  1'b0, 1'b0, 8'd0);
    push_beat(CMD_SET,     1'b0, 1'b0, 8'd255);
    push_beat(CMD_SAVE,    1'b0, 1'b0, 8'd0);
    push_beat(CMD_SET,     1'b1, 1'b1, 8'd17);
    push_beat(CMD_RESTORE, 1'b0, 1'b0, 8'd0);
    push_beat(CMD_SYNC,    1'b1, 1'b1, 8'd0);
    push_beat(CMD_SAMPLE,  1'b1, 1'b1, 8'd255);
    push_beat(CMD_FIRST_UNUSED, 1'b1, 1'b1, 8'd255);
    push_beat(CMD_LAST_UNUSED,  1'b0, 1'b0, 8'd0);
    walk_g = 2'd2;
    wait_drained();

    run_phase(8'd1,   8'd0,   8'd255, 70);
    run_phase(8'd255, 8'd255, 8'd255, 50);
    // zero divider: position reads all ones
    run_phase(8'd0,   8'd7,   8'd9,   50);
    write_reg(REG_SPARE, $urandom_range(0, 255));
    run_phase(8'd3,   8'd10,  8'd20,  80);
    run_phase(TicksReset, RangeFromReset, RangeToReset, 60);
    repeat (4) begin
      div = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
      lo  = $urandom_range(0, 40);
      run_phase(div, lo, lo + $urandom_range(0, 30), 75);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (position_reports_q.size() != 0) begin
      $error("%0d expected result beats never arrived", position_reports_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
